// ===== rtl/s2m_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and reset values for the sensor-to-MIDI event block.
// Used by every module under rtl/; depends on nothing.
package s2m_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam int RANGE_W   = 16;
    localparam int THRESH_W  = 17;
    localparam int CHANNEL_W = 5;
    localparam int NUMBER_W  = 7;
    localparam int VALUE_W   = 7;
    localparam int LAST_W    = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam int WIDE_W = 19;
    localparam int NUM_W  = 24;
    localparam int DEN_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIDI_CHAN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROLLER  = 3'd4;

    localparam logic [RANGE_W-1:0]   RANGE_LOW_RESET  = 16'd0;
    localparam logic [RANGE_W-1:0]   RANGE_HIGH_RESET = 16'd1023;
    localparam logic [THRESH_W-1:0]  THRESH_CONTINUOUS = 17'h1FFFF;
    localparam logic [CHANNEL_W-1:0] CHANNEL_RESET    = 5'd1;
    localparam logic [NUMBER_W-1:0]  CONTROLLER_RESET = 7'd0;

    localparam logic [LAST_W-1:0]  LAST_NONE   = 8'd255;
    localparam logic [LAST_W-1:0]  LAST_ON     = 8'd127;
    localparam logic [LAST_W-1:0]  LAST_OFF    = 8'd0;
    localparam logic [VALUE_W-1:0] VALUE_MAX   = 7'd127;
    localparam logic [VALUE_W-1:0] VALUE_ZERO  = 7'd0;

    typedef enum logic [1:0] {
        KIND_CONTROL  = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_NOTE_OFF = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [RANGE_W-1:0]   range_low;
        logic [RANGE_W-1:0]   range_high;
        logic [THRESH_W-1:0]  threshold;
        logic [CHANNEL_W-1:0] midi_channel;
        logic [NUMBER_W-1:0]  controller_number;
    } cfg_t;

endpackage

// ===== rtl/s2m_config_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file of the sensor-to-MIDI event block.
// Depends on s2m_pkg for the register indexes, widths and reset values.
module s2m_config_regs
    import s2m_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_RANGE_LOW:  cfg_next.range_low         = cfg_data[RANGE_W-1:0];
                REG_RANGE_HIGH: cfg_next.range_high        = cfg_data[RANGE_W-1:0];
                REG_THRESHOLD:  cfg_next.threshold         = cfg_data[THRESH_W-1:0];
                REG_MIDI_CHAN:  cfg_next.midi_channel      = cfg_data[CHANNEL_W-1:0];
                REG_CONTROLLER: cfg_next.controller_number = cfg_data[NUMBER_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_low         <= RANGE_LOW_RESET;
            cfg_reg.range_high        <= RANGE_HIGH_RESET;
            cfg_reg.threshold         <= THRESH_CONTINUOUS;
            cfg_reg.midi_channel      <= CHANNEL_RESET;
            cfg_reg.controller_number <= CONTROLLER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/s2m_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle with one subtractor.
// Depends on s2m_pkg for the dividend and divisor widths.
module s2m_divider
    import s2m_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int STEPS  = NUM_W;
    localparam int CNT_W  = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dq_reg, dq_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W+1:0] partial;
    logic [DEN_W+1:0] trial;
    logic             fits;

    assign partial = {1'b0, rem_reg, dq_reg[NUM_W-1]};
    assign trial   = partial - {2'b00, den_reg};
    assign fits    = !trial[DEN_W+1];
    assign done    = busy_reg && (cnt_reg == LAST_STEP);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DEN_W-1:0] : partial[DEN_W-1:0];
            dq_next  = {dq_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        den_reg <= den_next;
    end

    assign quotient = dq_reg;

endmodule

// ===== rtl/sensor_to_midi_event.sv =====
`timescale 1ns / 1ps
// Top level of the sensor-to-MIDI event block: sequencer, result register and ports.
// Depends on s2m_pkg, s2m_config_regs and s2m_divider.
//
// Each accepted sample beat occupies the block until its finish step ends, and
// no new sample is taken before then: a setup step forms the span and scaled
// offset, the one-bit-per-cycle restoring divider runs, and a finish step
// clamps, decides and loads the result register. If a previous result still
// sits unaccepted in the result register, the finish step waits for it.
// A sample yields zero or one message beat: a control change in continuous
// mode (threshold written as -1) when the mapped value changes, otherwise a
// note on or note off as the sample crosses the threshold.
module sensor_to_midi_event
    import s2m_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_W-1:0]    sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             message_kind,
    output logic [NUMBER_W-1:0]    message_number,
    output logic [VALUE_W-1:0]     message_value,
    output logic [CHANNEL_W-1:0]   message_channel
);

    cfg_t cfg;

    state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [LAST_W-1:0]      last_sent_reg, last_sent_next;
    logic                   force_zero_reg;

    logic                   out_valid_reg, out_valid_next;
    kind_t                  kind_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [NUMBER_W-1:0]    number_reg;
    logic [CHANNEL_W-1:0]   channel_reg;

    logic                   in_accept;
    logic                   div_start;
    logic                   div_done;
    logic                   finish_go;
    logic [NUM_W-1:0]       quotient;

    logic                   continuous;
    logic signed [WIDE_W-1:0] x_s;
    logic signed [WIDE_W-1:0] lo_s;
    logic signed [WIDE_W-1:0] hi_s;
    logic signed [WIDE_W-1:0] diff_s;
    logic signed [WIDE_W-1:0] span_s;
    logic [WIDE_W-1:0]      diff_abs;
    logic [WIDE_W-1:0]      span_abs;
    logic [NUM_W-1:0]       num_abs;
    logic                   force_zero;

    logic [VALUE_W-1:0]     scaled;
    logic                   emit;
    kind_t                  emit_kind;
    logic [VALUE_W-1:0]     emit_value;

    s2m_config_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Offset and span of the linear map; the magnitudes go to the divider and
    // the sign relation decides whether the result is clamped to zero.
    assign continuous = (cfg.threshold == THRESH_CONTINUOUS);
    assign x_s  = $signed(WIDE_W'(sample_reg));
    assign lo_s = continuous ? $signed(WIDE_W'(cfg.range_low))
                             : WIDE_W'($signed(cfg.threshold));
    assign hi_s = $signed(WIDE_W'(cfg.range_high));
    assign diff_s   = x_s - lo_s;
    assign span_s   = hi_s - lo_s;
    assign diff_abs = diff_s[WIDE_W-1] ? WIDE_W'(-diff_s) : WIDE_W'(diff_s);
    assign span_abs = span_s[WIDE_W-1] ? WIDE_W'(-span_s) : WIDE_W'(span_s);
    assign num_abs  = (NUM_W'(diff_abs[DEN_W-1:0]) << 7) - NUM_W'(diff_abs[DEN_W-1:0]);
    assign force_zero = (span_s == '0)
                     || ((diff_s != '0) && (diff_s[WIDE_W-1] != span_s[WIDE_W-1]));

    s2m_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_abs),
        .divisor  (span_abs[DEN_W-1:0]),
        .done     (div_done),
        .quotient (quotient)
    );

    assign scaled = force_zero_reg          ? VALUE_ZERO :
                    (|quotient[NUM_W-1:VALUE_W]) ? VALUE_MAX :
                    quotient[VALUE_W-1:0];

    always_comb
    begin
        emit           = 1'b0;
        emit_kind      = KIND_CONTROL;
        emit_value     = scaled;
        last_sent_next = last_sent_reg;
        if (continuous)
        begin
            if ({1'b0, scaled} != last_sent_reg)
            begin
                emit           = 1'b1;
                last_sent_next = {1'b0, scaled};
            end
        end
        else if ((x_s > lo_s) && (last_sent_reg != LAST_ON))
        begin
            emit           = 1'b1;
            emit_kind      = KIND_NOTE_ON;
            last_sent_next = LAST_ON;
        end
        else if ((x_s < lo_s) && (last_sent_reg != LAST_OFF))
        begin
            emit           = 1'b1;
            emit_kind      = KIND_NOTE_OFF;
            emit_value     = VALUE_ZERO;
            last_sent_next = LAST_OFF;
        end
    end

    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_accept) state_next = ST_SETUP;
            ST_SETUP:  state_next = ST_DIVIDE;
            ST_DIVIDE: if (div_done) state_next = ST_FINISH;
            ST_FINISH: if (!(out_valid_reg && out_stall)) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        div_start = (state_reg == ST_SETUP);
        finish_go = (state_reg == ST_FINISH) && !(out_valid_reg && out_stall);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (finish_go && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_sent_reg <= LAST_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (finish_go)
            begin
                last_sent_reg <= last_sent_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample[SAMPLE_BITS-1:0];
        end
        if (div_start)
        begin
            force_zero_reg <= force_zero;
        end
        if (finish_go && emit)
        begin
            kind_reg    <= emit_kind;
            value_reg   <= emit_value;
            number_reg  <= cfg.controller_number;
            channel_reg <= cfg.midi_channel;
        end
    end

    assign out_valid       = out_valid_reg;
    assign message_kind    = kind_reg;
    assign message_value   = value_reg;
    assign message_number  = number_reg;
    assign message_channel = channel_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_SETUP))
        else $error("Accepted sample beat did not start the setup step.");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        finish_go |-> !(out_valid_reg && out_stall))
        else $error("Result loaded over a held message beat.");

    a_note_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && emit && (emit_kind == KIND_NOTE_ON)) |=> (last_sent_reg == LAST_ON))
        else $error("Note on did not record the on state.");

    a_note_off_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (message_kind == KIND_NOTE_OFF)) |-> (message_value == VALUE_ZERO))
        else $error("Note off beat carries a nonzero value.");

    a_divide_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && div_done) |=> (state_reg == ST_FINISH))
        else $error("Divider completion did not reach the finish step.");

endmodule
